// ===== hdl/dlr_pkg.sv =====
`timescale 1ns / 1ps
package dlr_pkg;

    // default build configuration
    localparam int TILE_BITS_DEF  = 6;
    localparam int DEPTH_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 16;

    // stream widths
    localparam int IN_W   = 104;
    localparam int OUT_W  = 56;

    // input field offsets in s_tdata
    localparam int IN_SX  = 0;
    localparam int IN_SY  = 6;
    localparam int IN_SD  = 12;
    localparam int IN_EX  = 28;
    localparam int IN_EY  = 34;
    localparam int IN_ED  = 40;
    localparam int IN_R   = 56;
    localparam int IN_G   = 72;
    localparam int IN_B   = 88;

    localparam int COLOUR_SCALE = 255;

    // controller to datapath
    typedef struct packed {
        logic clr;   // write one clearing entry
        logic load;  // take a line command
        logic div;   // one divider iteration
        logic rd;    // read depth store at current pixel
        logic test;  // depth test, store, emit item, advance
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic clr_done;
        logic zero_len;
        logic div_done;
        logic last;
        logic out_free;
    } t_sts;

    // signed 8.8 to byte: scale by 255, truncate, clamp
    function automatic logic [7:0] colour_byte(input logic signed [15:0] c);
        logic [23:0] s;
        logic [7:0]  b;
        s = (24'(unsigned'(c)) << 8) - 24'(unsigned'(c));
        if (c <= 16'sd0) begin
            b = 8'd0;
        end else if (s[23:8] > 16'(COLOUR_SCALE)) begin
            b = 8'(COLOUR_SCALE);
        end else begin
            b = s[15:8];
        end
        return b;
    endfunction

endpackage

// ===== hdl/dlr_ctrl.sv =====
`timescale 1ns / 1ps
module dlr_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    input  dlr_pkg::t_sts i_sts,
    output dlr_pkg::t_cmd o_cmd
);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_DIV   = 5'b00100,
        S_READ  = 5'b01000,
        S_TEST  = 5'b10000
    } t_state;

    t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div = 1'b1;
                if (i_sts.zero_len || i_sts.div_done) n_state = S_READ;
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = S_TEST;
            end
            S_TEST: begin
                if (i_sts.out_free) begin
                    o_cmd.test = 1'b1;
                    n_state    = i_sts.last ? S_IDLE : S_READ;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

endmodule

// ===== hdl/dlr_datapath.sv =====
`timescale 1ns / 1ps
module dlr_datapath #(
    parameter int TILE_BITS  = dlr_pkg::TILE_BITS_DEF,
    parameter int DEPTH_BITS = dlr_pkg::DEPTH_BITS_DEF,
    parameter int FRAC_BITS  = dlr_pkg::FRAC_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  dlr_pkg::t_cmd            i_cmd,
    output dlr_pkg::t_sts            o_sts,
    input  logic [dlr_pkg::IN_W-1:0] i_s_tdata,
    output logic                     o_m_tvalid,
    input  logic                     i_m_tready,
    output logic [dlr_pkg::OUT_W-1:0] o_m_tdata,
    output logic                     o_m_tuser,
    output logic                     o_m_tlast
);

    localparam int AW    = TILE_BITS + FRAC_BITS + 1;
    localparam int DW    = (TILE_BITS + FRAC_BITS > DEPTH_BITS) ?
                           TILE_BITS + FRAC_BITS : DEPTH_BITS;
    localparam int DCW   = $clog2(DW + 1);
    localparam int STORE = 1 << (2 * TILE_BITS);
    localparam int OUT_W_L = dlr_pkg::OUT_W;

    // depth store
    logic [DEPTH_BITS-1:0]  r_mem [STORE];
    logic [DEPTH_BITS-1:0]  r_rdata;
    logic [2*TILE_BITS-1:0] r_clr_addr;
    logic [2*TILE_BITS-1:0] w_addr;
    logic                   w_we;
    logic [DEPTH_BITS-1:0]  w_wdata;

    // line registers
    logic [TILE_BITS-1:0]  r_steps, r_k, r_zr;
    logic [AW-1:0]         r_ax, r_ay;
    logic                  r_xneg, r_yneg, r_zneg;
    logic [DEPTH_BITS-1:0] r_z0, r_zq;
    logic [7:0]            r_red, r_grn, r_blu;

    // divider lanes
    logic [DW-1:0]        r_dx, r_dy, r_dz;
    logic [TILE_BITS-1:0] r_rx, r_ry, r_rz;
    logic [DCW-1:0]       r_dcnt;

    // output register
    logic                 r_ovalid;
    logic [OUT_W_L-1:0]   r_odata;
    logic                 r_ouser, r_olast;

    // command decode of inputs
    logic [TILE_BITS-1:0]  w_x0, w_y0, w_x1, w_y1, w_adx, w_ady, w_steps;
    logic [DEPTH_BITS-1:0] w_z0, w_z1, w_adz;
    logic [AW-1:0]         w_half;

    assign w_x0  = i_s_tdata[dlr_pkg::IN_SX +: TILE_BITS];
    assign w_y0  = i_s_tdata[dlr_pkg::IN_SY +: TILE_BITS];
    assign w_x1  = i_s_tdata[dlr_pkg::IN_EX +: TILE_BITS];
    assign w_y1  = i_s_tdata[dlr_pkg::IN_EY +: TILE_BITS];
    assign w_z0  = DEPTH_BITS'(i_s_tdata[dlr_pkg::IN_SD +: 16]);
    assign w_z1  = DEPTH_BITS'(i_s_tdata[dlr_pkg::IN_ED +: 16]);
    assign w_adx = (w_x1 >= w_x0) ? w_x1 - w_x0 : w_x0 - w_x1;
    assign w_ady = (w_y1 >= w_y0) ? w_y1 - w_y0 : w_y0 - w_y1;
    assign w_adz = (w_z1 >= w_z0) ? w_z1 - w_z0 : w_z0 - w_z1;
    assign w_steps = (w_adx > w_ady) ? w_adx : w_ady;
    assign w_half  = AW'(1) << (FRAC_BITS - 1);

    // restoring divider step, one quotient bit per lane
    function automatic logic [DW+TILE_BITS-1:0] div_step(
        input logic [DW-1:0] d, input logic [TILE_BITS-1:0] r,
        input logic [TILE_BITS-1:0] s);
        logic [TILE_BITS:0]   t;
        logic                 q;
        logic [TILE_BITS-1:0] rn;
        t = {r, d[DW-1]};
        q = (t >= {1'b0, s});
        rn = q ? TILE_BITS'(t - {1'b0, s}) : TILE_BITS'(t);
        return {rn, d[DW-2:0], q};
    endfunction

    // current pixel
    logic [TILE_BITS-1:0]  w_px, w_py;
    logic [DEPTH_BITS-1:0] w_z;
    logic                  w_pass;
    logic [TILE_BITS:0]    w_rsum;
    logic [FRAC_BITS:0]    w_xi, w_yi;

    assign w_px   = r_ax[FRAC_BITS +: TILE_BITS];
    assign w_py   = r_ay[FRAC_BITS +: TILE_BITS];
    assign w_z    = r_zneg ? r_z0 - r_zq : r_z0 + r_zq;
    assign w_pass = (w_z <= r_rdata);
    assign w_rsum = {1'b0, r_zr} + {1'b0, r_rz};
    assign w_xi   = r_dx[FRAC_BITS:0];
    assign w_yi   = r_dy[FRAC_BITS:0];

    // store port mux
    always_comb begin
        w_we    = i_cmd.clr | (i_cmd.test & w_pass);
        w_addr  = i_cmd.clr ? r_clr_addr : {w_py, w_px};
        w_wdata = i_cmd.clr ? '1 : w_z;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_addr] <= w_wdata;
        if (i_cmd.rd) r_rdata <= r_mem[{w_py, w_px}];
    end

    // clearing sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr) begin
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    // line setup, division and stepping
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_steps <= w_steps;
            r_k     <= '0;
            r_ax    <= (AW'(w_x0) << FRAC_BITS) | w_half;
            r_ay    <= (AW'(w_y0) << FRAC_BITS) | w_half;
            r_xneg  <= w_x1 < w_x0;
            r_yneg  <= w_y1 < w_y0;
            r_zneg  <= w_z1 < w_z0;
            r_z0    <= w_z0;
            r_zq    <= '0;
            r_zr    <= '0;
            r_dx    <= DW'(w_adx) << FRAC_BITS;
            r_dy    <= DW'(w_ady) << FRAC_BITS;
            r_dz    <= DW'(w_adz);
            r_rx    <= '0;
            r_ry    <= '0;
            r_rz    <= '0;
            r_dcnt  <= DCW'(DW);
            r_red   <= dlr_pkg::colour_byte(i_s_tdata[dlr_pkg::IN_R +: 16]);
            r_grn   <= dlr_pkg::colour_byte(i_s_tdata[dlr_pkg::IN_G +: 16]);
            r_blu   <= dlr_pkg::colour_byte(i_s_tdata[dlr_pkg::IN_B +: 16]);
        end else if (i_cmd.div) begin
            {r_rx, r_dx} <= div_step(r_dx, r_rx, r_steps);
            {r_ry, r_dy} <= div_step(r_dy, r_ry, r_steps);
            {r_rz, r_dz} <= div_step(r_dz, r_rz, r_steps);
            r_dcnt <= r_dcnt - 1'b1;
        end else if (i_cmd.test && !o_sts.last) begin
            r_k  <= r_k + 1'b1;
            r_ax <= r_xneg ? r_ax - AW'(w_xi) : r_ax + AW'(w_xi);
            r_ay <= r_yneg ? r_ay - AW'(w_yi) : r_ay + AW'(w_yi);
            if (w_rsum >= {1'b0, r_steps}) begin
                r_zr <= TILE_BITS'(w_rsum - {1'b0, r_steps});
                r_zq <= r_zq + r_dz[DEPTH_BITS-1:0] + 1'b1;
            end else begin
                r_zr <= TILE_BITS'(w_rsum);
                r_zq <= r_zq + r_dz[DEPTH_BITS-1:0];
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.test) begin
            r_ovalid <= 1'b1;
        end else if (i_m_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.test) begin
            r_odata <= {4'd0, r_blu, r_grn, r_red, 16'(w_z), 6'(w_py), 6'(w_px)};
            r_ouser <= w_pass;
            r_olast <= o_sts.last;
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;
    assign o_m_tuser  = r_ouser;
    assign o_m_tlast  = r_olast;

    // status
    always_comb begin
        o_sts.clr_done = &r_clr_addr;
        o_sts.zero_len = (r_steps == '0);
        o_sts.div_done = (r_dcnt == DCW'(1));
        o_sts.last     = (r_k == r_steps);
        o_sts.out_free = !r_ovalid || i_m_tready;
    end

endmodule

// ===== hdl/dda_line_depth_raster_unit.sv =====
`timescale 1ns / 1ps
// Line rasterizer with depth test for one tile. After reset the depth store
// (2^(2*TILE_BITS) entries, 4096 by default) is swept to farthest depth, one
// entry per cycle, with s_tready low. Each line item is then taken while idle,
// followed by a bit-serial setup division over max(TILE_BITS+FRAC_BITS,
// DEPTH_BITS) (22 by default) dividend bits (cut short for a zero-length line),
// and then each pixel goes through a read and a read-modify-write of the
// single depth store; the write step waits while the output register is full.
// One item per pixel comes out, in step order.
module dda_line_depth_raster_unit #(
    parameter int TILE_BITS  = dlr_pkg::TILE_BITS_DEF,
    parameter int DEPTH_BITS = dlr_pkg::DEPTH_BITS_DEF,
    parameter int FRAC_BITS  = dlr_pkg::FRAC_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_s_tvalid,
    output logic                      o_s_tready,
    // start_x, start_y, start_depth, end_x, end_y, end_depth, red_in,
    // green_in, blue_in
    input  logic [dlr_pkg::IN_W-1:0]  i_s_tdata,
    output logic                      o_m_tvalid,
    input  logic                      i_m_tready,
    // pixel_x, pixel_y, pixel_depth, red_out, green_out, blue_out, zero pad
    output logic [dlr_pkg::OUT_W-1:0] o_m_tdata,
    // written
    output logic                      o_m_tuser,
    output logic                      o_m_tlast
);

    dlr_pkg::t_cmd w_cmd;
    dlr_pkg::t_sts w_sts;

    dlr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    dlr_datapath #(
        .TILE_BITS  (TILE_BITS),
        .DEPTH_BITS (DEPTH_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

// ===== hdl/dlr_checker.sv =====
`timescale 1ns / 1ps
module dlr_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_s_tvalid,
    input logic                      o_s_tready,
    input logic                      o_m_tvalid,
    input logic                      i_m_tready,
    input logic [dlr_pkg::OUT_W-1:0] o_m_tdata,
    input logic                      o_m_tuser,
    input logic                      o_m_tlast
);

    // store sweep keeps input closed right after reset
    a_clear: assert property (@(posedge i_clk) !i_rst_n |=> !o_s_tready)
        else $error("input open during store clear");

    // one line at a time
    a_one_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("second line taken while busy");

    // when idle, a pending item can only be a line's final pixel
    a_idle_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_s_tready && o_m_tvalid) |-> o_m_tlast)
        else $error("idle with a mid-line pixel pending");

    // stalled item holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=>
        (o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser) && $stable(o_m_tlast)))
        else $error("output item changed under stall");

endmodule

bind dda_line_depth_raster_unit dlr_checker u_chk (.*);
